/* src/iks_pkg.sv */
// ----------------------------------------------------------------------------
// iks_pkg
// Shared constants, types and codes for the closest inverse-kinematics
// solution selector and its joint unit.
// ----------------------------------------------------------------------------
package iks_pkg;

  // joint and set sizes
  localparam int JOINT_COUNT    = 6;
  localparam int MAX_CANDIDATES = 8;
  localparam int JOINT_IDX_W    = 3;
  localparam int CNT_W          = 4;

  // angle formats: ANG_W is the port format, WIDE_W holds turn-shifted values
  // and differences against the current joints
  localparam int ANG_W  = 18;
  localparam int WIDE_W = 20;
  localparam int REM_W  = 16;
  localparam int SQ_W   = 2 * WIDE_W;
  localparam int ACC_W  = 44;
  localparam int DIST_W = 40;

  // stream payload widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_IDX_W  = 3;

  // 2pi and pi in Q5.13, rounded to nearest
  localparam logic [ANG_W-1:0]         TWO_PI_MAG  = 18'd51472;
  localparam logic [ANG_W-1:0]         FOUR_PI_MAG = 18'd102944;
  localparam logic signed [WIDE_W-1:0] TWO_PI_W    = 20'sd51472;
  localparam logic signed [WIDE_W-1:0] PI_W        = 20'sd25736;
  localparam logic signed [WIDE_W-1:0] NEG_PI_W    = -20'sd25736;
  localparam logic signed [WIDE_W-1:0] ANG_MAX_W   = 20'sd131071;
  localparam logic signed [WIDE_W-1:0] ANG_MIN_W   = -20'sd131072;
  localparam logic signed [WIDE_W-1:0] ZERO_W      = '0;

  // distance saturation
  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
  localparam logic [ACC_W-1:0]  DIST_MAX_ACC = {{(ACC_W-DIST_W){1'b0}}, DIST_MAX};

  // joint indexes
  localparam logic [JOINT_IDX_W-1:0] FIRST_WRIST = 3'd3;
  localparam logic [JOINT_IDX_W-1:0] LAST_JOINT  = 3'd5;
  localparam logic [JOINT_IDX_W-1:0] WRIST2_IDX  = 3'd4;
  localparam logic [JOINT_IDX_W-1:0] BASE_IDX    = 3'd0;

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CAND  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRIST_ONLY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W1_UPPER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W1_LOWER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W2_UPPER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W2_LOWER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_W3_UPPER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_W3_LOWER   = 3'd6;

  // bound reset values
  localparam logic signed [ANG_W-1:0] W1_UPPER_RST = -18'sd4289;
  localparam logic signed [ANG_W-1:0] W1_LOWER_RST = -18'sd34315;
  localparam logic signed [ANG_W-1:0] W2_UPPER_RST = 18'sd0;
  localparam logic signed [ANG_W-1:0] W2_LOWER_RST = -18'sd25736;
  localparam logic signed [ANG_W-1:0] W3_UPPER_RST = 18'sd715;
  localparam logic signed [ANG_W-1:0] W3_LOWER_RST = -18'sd31455;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } iks_state_t;

  // one joint handed to the joint unit
  typedef struct packed {
    logic                   valid;
    logic [JOINT_IDX_W-1:0] idx;
    logic                   wrist;
    logic [ANG_W-1:0]       angle;
    logic [ANG_W-1:0]       now;
    logic [ANG_W-1:0]       up;
    logic [ANG_W-1:0]       lo;
  } joint_req_t;

  // one joint coming back from the joint unit
  typedef struct packed {
    logic                   valid;
    logic [JOINT_IDX_W-1:0] idx;
    logic [ANG_W-1:0]       q;
    logic                   ok;
    logic [ACC_W-1:0]       term;
  } joint_res_t;

endpackage

/* src/iks_joint_unit.sv */
// ----------------------------------------------------------------------------
// iks_joint_unit
// Seven-stage joint unit: wraps one candidate angle, applies the wrist bound
// shift and the nearer-turn choice, and forms its weighted squared distance
// to the current joint. Takes one joint per cycle.
// ----------------------------------------------------------------------------
module iks_joint_unit
  import iks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  joint_req_t req,
  output joint_res_t res
);

  // stage valid bits
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  logic [JOINT_IDX_W-1:0] s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r, s6_idx_r;
  logic s1_wrist_r, s2_wrist_r, s3_wrist_r, s4_wrist_r, s5_wrist_r, s6_wrist_r;
  logic s3_ok_r, s4_ok_r, s5_ok_r, s6_ok_r;
  logic signed [WIDE_W-1:0] s1_now_r, s2_now_r, s3_now_r;
  logic signed [WIDE_W-1:0] s1_up_r, s1_lo_r, s2_up_r, s2_lo_r;
  logic                     s1_neg_r;
  logic [REM_W-1:0]         s1_rem_r;
  logic signed [WIDE_W-1:0] s2_q_r, s3_q_r, s4_q_r, s4_alt_r, s4_dg_r, s4_da_r;
  logic                     s4_turn_r;
  logic [ANG_W-1:0]         s5_q_r, s6_q_r;
  logic [WIDE_W-1:0]        s5_dmag_r;
  logic [SQ_W-1:0]          s6_sq_r;
  joint_res_t               res_r;

  // stage 0: magnitude reduced modulo 2pi
  logic [ANG_W-1:0] s0_mag, s0_rem;
  logic signed [WIDE_W-1:0] s0_now, s0_up, s0_lo;

  assign s0_mag = req.angle[ANG_W-1] ? (~req.angle + 1'b1) : req.angle;
  assign s0_now = $signed({{(WIDE_W-ANG_W){req.now[ANG_W-1]}}, req.now});
  assign s0_up  = $signed({{(WIDE_W-ANG_W){req.up[ANG_W-1]}}, req.up});
  assign s0_lo  = $signed({{(WIDE_W-ANG_W){req.lo[ANG_W-1]}}, req.lo});

  always_comb begin
    if (s0_mag >= FOUR_PI_MAG) begin
      s0_rem = s0_mag - FOUR_PI_MAG;
    end else if (s0_mag >= TWO_PI_MAG) begin
      s0_rem = s0_mag - TWO_PI_MAG;
    end else begin
      s0_rem = s0_mag;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= req.idx;
    s1_wrist_r <= req.wrist;
    s1_neg_r   <= req.angle[ANG_W-1];
    s1_rem_r   <= s0_rem[REM_W-1:0];
    s1_now_r   <= s0_now;
    s1_up_r    <= s0_up;
    s1_lo_r    <= s0_lo;
  end

  // stage 1: restore sign and fold into plus or minus pi
  logic signed [WIDE_W-1:0] s1_mag_s, s1_w, s1_fold;

  assign s1_mag_s = $signed({{(WIDE_W-REM_W){1'b0}}, s1_rem_r});
  assign s1_w     = s1_neg_r ? -s1_mag_s : s1_mag_s;

  always_comb begin
    if (s1_w > PI_W) begin
      s1_fold = s1_w - TWO_PI_W;
    end else if (s1_w < NEG_PI_W) begin
      s1_fold = s1_w + TWO_PI_W;
    end else begin
      s1_fold = s1_w;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_r   <= s1_idx_r;
    s2_wrist_r <= s1_wrist_r;
    s2_q_r     <= s1_fold;
    s2_now_r   <= s1_now_r;
    s2_up_r    <= s1_up_r;
    s2_lo_r    <= s1_lo_r;
  end

  // stage 2: wrist bound shift and bound check, normal rule only
  logic                     s2_bound_en;
  logic signed [WIDE_W-1:0] s2_qb;
  logic                     s2_ok;

  assign s2_bound_en = !s2_wrist_r && (s2_idx_r >= FIRST_WRIST);

  always_comb begin
    s2_qb = s2_q_r;
    if (s2_bound_en) begin
      if (s2_q_r > s2_up_r) begin
        s2_qb = s2_q_r - TWO_PI_W;
      end else if (s2_q_r < s2_lo_r) begin
        s2_qb = s2_q_r + TWO_PI_W;
      end
    end
  end

  assign s2_ok = !s2_bound_en || ((s2_qb > s2_lo_r) && (s2_qb < s2_up_r));

  always_ff @(posedge clk) begin
    s3_idx_r   <= s2_idx_r;
    s3_wrist_r <= s2_wrist_r;
    s3_q_r     <= s2_qb;
    s3_ok_r    <= s2_ok;
    s3_now_r   <= s2_now_r;
  end

  // stage 3: other turn and both differences
  logic signed [WIDE_W-1:0] s3_alt;

  assign s3_alt = (s3_q_r > ZERO_W) ? (s3_q_r - TWO_PI_W) : (s3_q_r + TWO_PI_W);

  always_ff @(posedge clk) begin
    s4_idx_r   <= s3_idx_r;
    s4_wrist_r <= s3_wrist_r;
    s4_ok_r    <= s3_ok_r;
    s4_q_r     <= s3_q_r;
    s4_alt_r   <= s3_alt;
    s4_dg_r    <= s3_now_r - s3_q_r;
    s4_da_r    <= s3_now_r - s3_alt;
    s4_turn_r  <= (s3_idx_r >= FIRST_WRIST) || ((s3_idx_r == BASE_IDX) && !s3_wrist_r);
  end

  // stage 4: pick the nearer turn, saturate the angle
  logic [WIDE_W-1:0]        s4_mag_g, s4_mag_a;
  logic                     s4_pick_go;
  logic signed [WIDE_W-1:0] s4_qf;
  logic [ANG_W-1:0]         s4_qsat;

  assign s4_mag_g   = s4_dg_r[WIDE_W-1] ? WIDE_W'(-s4_dg_r) : WIDE_W'(s4_dg_r);
  assign s4_mag_a   = s4_da_r[WIDE_W-1] ? WIDE_W'(-s4_da_r) : WIDE_W'(s4_da_r);
  assign s4_pick_go = !s4_turn_r || (s4_mag_g < s4_mag_a);
  assign s4_qf      = s4_pick_go ? s4_q_r : s4_alt_r;

  always_comb begin
    if (s4_qf > ANG_MAX_W) begin
      s4_qsat = ANG_MAX_W[ANG_W-1:0];
    end else if (s4_qf < ANG_MIN_W) begin
      s4_qsat = ANG_MIN_W[ANG_W-1:0];
    end else begin
      s4_qsat = s4_qf[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s5_idx_r   <= s4_idx_r;
    s5_wrist_r <= s4_wrist_r;
    s5_ok_r    <= s4_ok_r;
    s5_q_r     <= s4_qsat;
    s5_dmag_r  <= s4_pick_go ? s4_mag_g : s4_mag_a;
  end

  // stage 5: square the difference
  always_ff @(posedge clk) begin
    s6_idx_r   <= s5_idx_r;
    s6_wrist_r <= s5_wrist_r;
    s6_ok_r    <= s5_ok_r;
    s6_q_r     <= s5_q_r;
    s6_sq_r    <= s5_dmag_r * s5_dmag_r;
  end

  // stage 6: weight the square
  logic [ACC_W-1:0] s6_ext, s6_term;
  logic             s6_arm;

  assign s6_ext = {{(ACC_W-SQ_W){1'b0}}, s6_sq_r};
  assign s6_arm = (s6_idx_r < FIRST_WRIST);

  always_comb begin
    if (s6_arm && s6_wrist_r) begin
      s6_term = '0;
    end else if (s6_arm) begin
      s6_term = s6_ext + (s6_ext << 3);
    end else begin
      s6_term = s6_ext;
    end
  end

  always_ff @(posedge clk) begin
    res_r.idx  <= s6_idx_r;
    res_r.q    <= s6_q_r;
    res_r.ok   <= s6_ok_r;
    res_r.term <= s6_term;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      s1_valid_r  <= req.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      res_r.valid <= s6_valid_r;
    end
  end

  assign res = res_r;

endmodule

/* src/ik_solution_selector.sv */
// ----------------------------------------------------------------------------
// ik_solution_selector
// Picks, from a set of up to eight six-joint inverse-kinematics candidates,
// the acceptable one closest to the arm's current joints. A mode-0 beat loads
// the current joints. A mode-1 beat is one candidate: its six joints go one
// per cycle through a seven-stage joint unit, and the sequencer then compares
// the summed distance with the best so far. A mode-2 beat closes the set.
// The input is not ready while a candidate is in work or a result waits to
// be loaded into the output register. Configuration writes are always taken
// and must only come while the block is idle.
// ----------------------------------------------------------------------------
module ik_solution_selector
  import iks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // angle_0 .. angle_5, zero pad
  input  logic [1:0]            in_tuser,   // mode
  input  logic                  in_tlast,   // last_candidate
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // best_angle_0 .. best_angle_5, candidate_count
  output logic                  out_tuser,  // found
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ANG_W-1:0]      cfg_data
);

  iks_state_t state_r, state_nxt;

  logic                   wrist_only_r;
  logic [ANG_W-1:0]       w1_up_r, w1_lo_r, w2_up_r, w2_lo_r, w3_up_r, w3_lo_r;
  logic [ANG_W-1:0]       cur_r  [JOINT_COUNT];
  logic [ANG_W-1:0]       cand_r [JOINT_COUNT];
  logic [ANG_W-1:0]       q_r    [JOINT_COUNT];
  logic [ANG_W-1:0]       best_r [JOINT_COUNT];
  logic                   last_r;
  logic [JOINT_IDX_W-1:0] issue_r;
  logic [ACC_W-1:0]       acc_r;
  logic                   ok_r;
  logic [DIST_W-1:0]      best_dist_r;
  logic                   have_best_r;
  logic [CNT_W-1:0]       seen_r;
  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic                   out_tuser_r;

  logic       in_acc, out_free, emit_go;
  joint_req_t req;
  joint_res_t res;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign emit_go  = (state_r == S_EMIT) && out_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrist_only_r <= 1'b0;
      w1_up_r      <= W1_UPPER_RST;
      w1_lo_r      <= W1_LOWER_RST;
      w2_up_r      <= W2_UPPER_RST;
      w2_lo_r      <= W2_LOWER_RST;
      w3_up_r      <= W3_UPPER_RST;
      w3_lo_r      <= W3_LOWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WRIST_ONLY: wrist_only_r <= cfg_data[0];
        CFG_W1_UPPER:   w1_up_r      <= cfg_data;
        CFG_W1_LOWER:   w1_lo_r      <= cfg_data;
        CFG_W2_UPPER:   w2_up_r      <= cfg_data;
        CFG_W2_LOWER:   w2_lo_r      <= cfg_data;
        CFG_W3_UPPER:   w3_up_r      <= cfg_data;
        CFG_W3_LOWER:   w3_lo_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == MODE_CAND) begin
            state_nxt = S_ISSUE;
          end else if (in_tuser == MODE_CLOSE) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ISSUE: begin
        if (issue_r == LAST_JOINT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res.valid && (res.idx == LAST_JOINT)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (last_r || (seen_r >= CNT_W'(MAX_CANDIDATES))) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // current joints and the candidate being worked on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        cur_r[j] <= '0;
      end
    end else if (in_acc && (in_tuser == MODE_LOAD)) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        cur_r[j] <= in_tdata[ANG_W*j +: ANG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_CAND)) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        cand_r[j] <= in_tdata[ANG_W*j +: ANG_W];
      end
      last_r <= in_tlast;
    end
  end

  // joint issue counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= '0;
    end else if (state_r == S_ISSUE) begin
      issue_r <= (issue_r == LAST_JOINT) ? '0 : issue_r + 1'b1;
    end
  end

  // joint request
  always_comb begin
    req.valid = (state_r == S_ISSUE);
    req.idx   = issue_r;
    req.wrist = wrist_only_r;
    req.angle = cand_r[issue_r];
    req.now   = cur_r[issue_r];
    case (issue_r)
      FIRST_WRIST: begin
        req.up = w1_up_r;
        req.lo = w1_lo_r;
      end
      WRIST2_IDX: begin
        req.up = w2_up_r;
        req.lo = w2_lo_r;
      end
      LAST_JOINT: begin
        req.up = w3_up_r;
        req.lo = w3_lo_r;
      end
      default: begin
        req.up = '0;
        req.lo = '0;
      end
    endcase
  end

  iks_joint_unit u_joint (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  // collect joint results
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_CAND)) begin
      acc_r <= '0;
      ok_r  <= 1'b1;
    end else if (res.valid) begin
      acc_r        <= acc_r + res.term;
      ok_r         <= ok_r && res.ok;
      q_r[res.idx] <= res.q;
    end
  end

  // candidate decision
  logic [DIST_W-1:0] dist_sat;
  logic              cur0_neg, cur0_pos, q0_neg, q0_pos, skip, take;

  assign dist_sat = (acc_r > DIST_MAX_ACC) ? DIST_MAX : acc_r[DIST_W-1:0];
  assign cur0_neg = cur_r[0][ANG_W-1];
  assign cur0_pos = !cur_r[0][ANG_W-1] && (cur_r[0] != '0);
  assign q0_neg   = q_r[0][ANG_W-1];
  assign q0_pos   = !q_r[0][ANG_W-1] && (q_r[0] != '0);
  assign skip     = wrist_only_r && ((cur0_neg && q0_pos) || (cur0_pos && q0_neg));
  assign take     = ok_r && !skip && (!have_best_r || (dist_sat < best_dist_r));

  // best so far and set count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        best_r[j] <= '0;
      end
      best_dist_r <= DIST_MAX;
      have_best_r <= 1'b0;
      seen_r      <= '0;
    end else if (emit_go) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        best_r[j] <= '0;
      end
      best_dist_r <= DIST_MAX;
      have_best_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      if (in_acc && (in_tuser == MODE_CAND) && (seen_r != {CNT_W{1'b1}})) begin
        seen_r <= seen_r + 1'b1;
      end
      if ((state_r == S_DECIDE) && take) begin
        for (int j = 0; j < JOINT_COUNT; j++) begin
          best_r[j] <= q_r[j];
        end
        best_dist_r <= dist_sat;
        have_best_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        out_tdata_r[ANG_W*j +: ANG_W] <= best_r[j];
      end
      out_tdata_r[OUT_DATA_W-1 -: CNT_W] <= seen_r;
      out_tuser_r <= have_best_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // joint results only come back while a candidate is in work
  a_res_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == S_ISSUE || state_r == S_DRAIN))
    else $error("joint result outside candidate work");

  // the set never grows past its limit
  a_seen_limit: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(MAX_CANDIDATES))
    else $error("candidate count past set limit");

  // a not-found result carries zero angles
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r[ANG_W*JOINT_COUNT-1:0] == '0))
    else $error("not-found result with nonzero angles");

  // the best is only dropped by closing a set
  a_best_cleared_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(have_best_r) |-> ($past(state_r) == S_EMIT))
    else $error("best solution lost outside emit");

  // a candidate in work blocks the input
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> !in_tready || $past(res.valid && res.idx == LAST_JOINT))
    else $error("input ready while candidate in work");
`endif

endmodule
